/* rtl/tncl_pkg.sv */
// Package: shared types, constants and codes for the top-N candidate list.
package tncl_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int ID_BITS     = 16;
	localparam int VOTE_BITS   = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W       = 5;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	// outcome codes
	localparam logic [1:0] OUT_REJECT  = 2'd0;
	localparam logic [1:0] OUT_DUP     = 2'd1;
	localparam logic [1:0] OUT_APPEND  = 2'd2;
	localparam logic [1:0] OUT_REPLACE = 2'd3;

	// register word indexes (paddr[2])
	localparam logic REG_MIN_VOTES = 1'b0;
	localparam logic REG_CAPACITY  = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

	typedef struct packed {
		logic [ID_BITS-1:0]   template_id;
		logic [VOTE_BITS-1:0] vote_count;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         outcome;
		logic [IDX_W-1:0]   slot;
		logic [ID_BITS-1:0] evicted_id;
		logic [CNT_W-1:0]   entry_count;
		logic               has_entries;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic fin;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip;
		logic match;
		logic last;
	} dp_stat_t;

endpackage

/* rtl/tncl_dp.sv */
// Datapath: entry store, sequential duplicate/minimum scan, result register.
module tncl_dp
	import tncl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             cmd,
	output dp_stat_t             stat,
	input  in_beat_t             in_data,
	input  logic [VOTE_BITS-1:0] min_votes,
	input  logic [CAP_W-1:0]     capacity,
	output out_beat_t            out_data
);

	logic [ID_BITS-1:0]   ids_q   [MAX_ENTRIES];
	logic [VOTE_BITS-1:0] votes_q [MAX_ENTRIES];
	logic [CNT_W-1:0]     count_q;

	logic [ID_BITS-1:0]   id_q;
	logic [VOTE_BITS-1:0] vote_q;
	logic                 reject_q;
	logic                 dup_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [VOTE_BITS-1:0] best_vote_q;
	logic [ID_BITS-1:0]   best_id_q;
	out_beat_t            res_q;

	logic [ID_BITS-1:0]   rd_id;
	logic [VOTE_BITS-1:0] rd_vote;
	logic [CNT_W-1:0]     cap_eff;
	logic [CNT_W-1:0]     cnt_next;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	out_beat_t            res_d;

	assign rd_id   = ids_q[idx_q];
	assign rd_vote = votes_q[idx_q];

	// zero acts as one, anything past the store saturates
	always_comb begin
		if (capacity == '0) begin
			cap_eff = CNT_W'(1);
		end else if (capacity > CAP_W'(MAX_ENTRIES)) begin
			cap_eff = CNT_W'(MAX_ENTRIES);
		end else begin
			cap_eff = CNT_W'(capacity);
		end
	end

	assign stat.skip  = (in_data.vote_count < min_votes) || (count_q == '0);
	assign stat.match = (rd_id == id_q);
	assign stat.last  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	// final decision
	always_comb begin
		res_d    = '0;
		cnt_next = count_q;
		wr_en    = 1'b0;
		wr_idx   = best_idx_q;
		priority if (reject_q) begin
			res_d.outcome = OUT_REJECT;
		end else if (dup_q) begin
			res_d.outcome = OUT_DUP;
			res_d.slot    = idx_q;
		end else if (count_q < cap_eff) begin
			res_d.outcome = OUT_APPEND;
			wr_idx        = count_q[IDX_W-1:0];
			res_d.slot    = wr_idx;
			wr_en         = 1'b1;
			cnt_next      = count_q + CNT_W'(1);
		end else begin
			res_d.outcome    = OUT_REPLACE;
			res_d.slot       = best_idx_q;
			res_d.evicted_id = best_id_q;
			wr_en            = 1'b1;
		end
		res_d.entry_count = cnt_next;
		res_d.has_entries = (cnt_next != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.fin) begin
			count_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin && wr_en) begin
			ids_q[wr_idx]   <= id_q;
			votes_q[wr_idx] <= vote_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q     <= in_data.template_id;
			vote_q   <= in_data.vote_count;
			reject_q <= (in_data.vote_count < min_votes);
			dup_q    <= 1'b0;
			idx_q    <= '0;
		end else if (cmd.scan) begin
			if (stat.match) begin
				dup_q <= 1'b1;     // hold idx_q: it is the duplicate's slot
			end else begin
				if (idx_q == '0 || rd_vote < best_vote_q) begin
					best_idx_q  <= idx_q;
					best_vote_q <= rd_vote;
					best_id_q   <= rd_id;
				end
				idx_q <= idx_q + IDX_W'(1);
			end
		end
		if (cmd.fin) begin
			res_q <= res_d;
		end
	end

	assign out_data = res_q;

endmodule

/* rtl/tncl_ctrl.sv */
// Controller: sequences load, scan and finish; owns the output valid.
module tncl_ctrl
	import tncl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.skip ? ST_FIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.match || stat.last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/top_n_candidate_list.sv */
// Top level: top-N candidate list with APB registers, controller and datapath.
//
//  channel | dir | payload    | handshake
//  --------+-----+------------+---------------------------------------------
//  in      | in  | in_beat_t  | in_valid / in_stall, beat when valid & !stall
//  out     | out | out_beat_t | out_valid / out_stall, beat when valid & !stall
//  cfg     | in  | 32b words  | APB write, psel & penable & pwrite & pready
//
// An offer runs as load, scan and finish: the load takes the beat, the scan reads the entry store one entry
//   per cycle (over the stored entries, cut short at a duplicate), the finish decides and writes.
//   Rejected offers and offers into an empty list skip the scan.
// in_stall is high from the load until the result is in the output register.
// The finish step waits while a previous result is held by out_stall.
// Reset empties the list; entry contents are left as they are and never read unwritten.
module top_n_candidate_list
	import tncl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// offer beats
	input  logic              in_valid,
	output logic              in_stall,
	input  in_beat_t          in_data,
	// result beats
	output logic              out_valid,
	input  logic              out_stall,
	output out_beat_t         out_data,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [VOTE_BITS-1:0] min_votes_q;
	logic [CAP_W-1:0]     capacity_q;
	logic                 cfg_wr;
	ctl_cmd_t             cmd;
	dp_stat_t             stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// register word is picked by paddr[2]; byte offset ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_votes_q <= '0;
			capacity_q  <= CAP_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MIN_VOTES: min_votes_q <= pwdata[VOTE_BITS-1:0];
				REG_CAPACITY:  capacity_q  <= pwdata[CAP_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MIN_VOTES: prdata = DATA_W'(min_votes_q);
			REG_CAPACITY:  prdata = DATA_W'(capacity_q);
			default:       prdata = '0;
		endcase
	end

	tncl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tncl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.min_votes (min_votes_q),
		.capacity  (capacity_q),
		.out_data  (out_data)
	);

endmodule

/* rtl/tncl_chk.sv */
// Checker: port-level assertions for the candidate list, bound to the top level.
module tncl_chk
	import tncl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input out_beat_t         out_data
);

	// held result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_has_entries: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.has_entries == (out_data.entry_count != '0))
		else $error("has_entries disagrees with entry_count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_count <= CNT_W'(MAX_ENTRIES))
		else $error("entry_count beyond list size");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.outcome != OUT_REPLACE |-> out_data.evicted_id == '0)
		else $error("evicted_id set without a replacement");

endmodule

bind top_n_candidate_list tncl_chk u_tncl_chk (.*);

/* test/top_n_candidate_list_test.sv */
// Testbench for top_n_candidate_list: scoreboard-checked offers under random flow control.
`timescale 1ns / 1ps

module top_n_candidate_list_test;
	import tncl_pkg::*;

	// Long receiver hold-off, long enough for the block to back up into in_stall.
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 10;
	localparam int PHASE_OFFERS  = 195;

	// Mirror of the candidate list: tracks the entry store and the two registers,
	// predicts one result per accepted offer and checks results in order.
	class cand_list_board;
		logic [ID_BITS-1:0]   ids   [MAX_ENTRIES];
		logic [VOTE_BITS-1:0] votes [MAX_ENTRIES];
		int                   count;
		logic [15:0]          min_votes;
		logic [CAP_W-1:0]     capacity;
		out_beat_t            expected_results[$];
		int                   errors;

		function new();
			count     = 0;
			min_votes = '0;
			capacity  = CAP_RESET;
			errors    = 0;
		endfunction

		function void set_reg(logic sel, logic [DATA_W-1:0] val);
			if (sel == REG_MIN_VOTES) begin
				min_votes = val[15:0];
			end else begin
				capacity = val[CAP_W-1:0];
			end
		endfunction

		function void note_offer(in_beat_t b);
			int        cap;
			int        best;
			bit        dup;
			out_beat_t e;
			cap = int'(capacity);
			// zero counts as one, anything past the store saturates
			if (cap == 0) cap = 1;
			if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
			e = '0;
			e.outcome = OUT_REJECT;
			if (b.vote_count >= min_votes) begin
				dup = 0;
				for (int i = 0; i < count; i++) begin
					if (!dup && ids[i] == b.template_id) begin
						dup = 1;
						e.slot = IDX_W'(i);
					end
				end
				if (dup) begin
					e.outcome = OUT_DUP;
				end else if (count < cap) begin
					e.slot = IDX_W'(count);
					ids[count]   = b.template_id;
					votes[count] = b.vote_count;
					count++;
					e.outcome = OUT_APPEND;
				end else begin
					// full (or capacity lowered below count): least votes, lowest index on ties
					best = 0;
					for (int i = 1; i < count; i++) begin
						if (votes[i] < votes[best]) best = i;
					end
					e.slot       = IDX_W'(best);
					e.evicted_id = ids[best];
					ids[best]    = b.template_id;
					votes[best]  = b.vote_count;
					e.outcome    = OUT_REPLACE;
				end
			end
			e.entry_count = CNT_W'(count);
			e.has_entries = (count != 0);
			expected_results.push_back(e);
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t e;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: got %h", $time, got);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			if (got.outcome !== e.outcome) begin
				$display("%0t: outcome expected %0d got %0d", $time, e.outcome, got.outcome);
				errors++;
			end
			if (got.slot !== e.slot) begin
				$display("%0t: slot expected %0d got %0d", $time, e.slot, got.slot);
				errors++;
			end
			if (got.evicted_id !== e.evicted_id) begin
				$display("%0t: evicted_id expected %h got %h", $time, e.evicted_id,
					got.evicted_id);
				errors++;
			end
			if (got.entry_count !== e.entry_count) begin
				$display("%0t: entry_count expected %0d got %0d", $time, e.entry_count,
					got.entry_count);
				errors++;
			end
			if (got.has_entries !== e.has_entries) begin
				$display("%0t: has_entries expected %0d got %0d", $time, e.has_entries,
					got.has_entries);
				errors++;
			end
		endfunction
	endclass

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_beat_t          in_data  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_beat_t         out_data;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// no_idle: both sides run without gaps for a stretch
	// hold_req: receiver takes one long hold-off at its next beat
	bit no_idle  = 1'b0;
	bit hold_req = 1'b0;

	cand_list_board board = new();

	always #5 clk = ~clk;

	top_n_candidate_list dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Offer one beat. Called at a clock edge; returns at the edge that accepted it,
	// leaving in_valid high so a back-to-back offer never toggles it in one step.
	task automatic send_offer(in_beat_t b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_offer(b);
	endtask

	// APB write; with more set psel stays high for a back-to-back write
	task automatic write_reg(logic sel, logic [DATA_W-1:0] val, bit more);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_reg(sel, val);
		if (!more) begin
			psel    <= 1'b0;
			penable <= 1'b0;
			pwrite  <= 1'b0;
		end
	endtask

	// Drop the offer, then wait until every predicted result is back.
	// One result per offer, so an empty queue means the block is idle.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [15:0] thresh, logic [CAP_W-1:0] cap);
		drain();
		write_reg(REG_MIN_VOTES, DATA_W'(thresh), 1'b1);
		write_reg(REG_CAPACITY, DATA_W'(cap), 1'b0);
	endtask

	// IDs mostly from a small pool so duplicates and evictions are common;
	// votes cluster at the threshold and repeat so that ties occur.
	function automatic in_beat_t rand_offer(logic [15:0] thresh);
		in_beat_t b;
		int       r;
		int       v;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			b.template_id = 16'($urandom_range(0, 23));
		end else if (r < 8) begin
			b.template_id = 16'($urandom);
		end else begin
			b.template_id = 16'hFFFF - 16'($urandom_range(0, 7));
		end
		r = $urandom_range(0, 9);
		if (r < 4) begin
			v = int'($urandom_range(0, 65535));
		end else if (r < 7) begin
			v = int'(thresh) + int'($urandom_range(0, 8)) - 3;
		end else begin
			v = int'(thresh) + int'($urandom_range(0, 3));
		end
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		b.vote_count = 16'(v);
		return b;
	endfunction

	// Result side: a random stall before each beat, or one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 10);
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			board.check_result(out_data);
		end
	end

	// Stimulus: directed corners, then random phases across register settings.
	// The stored count never shrinks (only reset empties the list), so the early
	// phases raise capacity in steps to keep the append path busy.
	initial begin
		logic [15:0]      thresh;
		logic [CAP_W-1:0] cap;
		in_beat_t         b;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: threshold 0, capacity 16
		send_offer('{template_id: 16'h0000, vote_count: 16'h0000});  // zero votes still pass
		send_offer('{template_id: 16'h0000, vote_count: 16'hFFFF});  // duplicate at slot 0
		send_offer('{template_id: 16'hFFFF, vote_count: 16'hFFFF});  // append, max fields

		// capacity zero acts as one, and is already below the stored count of two
		configure(16'hFFFF, 5'd0);
		send_offer('{template_id: 16'h1234, vote_count: 16'hFFFE});  // one below threshold
		send_offer('{template_id: 16'h5555, vote_count: 16'hFFFF});  // evicts slot 0
		send_offer('{template_id: 16'hAAAA, vote_count: 16'hFFFF});  // tie, lowest index wins
		send_offer('{template_id: 16'hFFFF, vote_count: 16'hFFFF});  // duplicate at slot 1

		// capacity past the store saturates to MAX_ENTRIES
		configure(16'h0000, 5'd31);
		send_offer('{template_id: 16'h0F0F, vote_count: 16'h0000});
		send_offer('{template_id: 16'hF0F0, vote_count: 16'h8000});

		// capacity lowered below the stored count: full, count holds at four
		configure(16'h0001, 5'd3);
		send_offer('{template_id: 16'h0001, vote_count: 16'h0000});  // rejected
		send_offer('{template_id: 16'h0001, vote_count: 16'h0001});  // evicts 0F0F
		send_offer('{template_id: 16'h7FFF, vote_count: 16'h7FFF});

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin thresh = 16'd20;    cap = 5'd6;  end
				1: begin thresh = 16'h8000;  cap = 5'd9;  end
				2: begin thresh = 16'd0;     cap = 5'd12; end
				3: begin thresh = 16'hFFFF;  cap = 5'd16; end
				4: begin thresh = 16'd300;   cap = 5'd31; end
				5: begin thresh = 16'd1000;  cap = 5'd3;  end
				6: begin thresh = 16'd0;     cap = 5'd0;  end
				7: begin thresh = 16'($urandom); cap = 5'd1; end
				8: begin thresh = 16'($urandom); cap = 5'($urandom_range(0, 31)); end
				default: begin thresh = 16'd0; cap = CAP_RESET; end
			endcase
			configure(thresh, cap);
			for (int n = 0; n < PHASE_OFFERS; n++) begin
				if ($urandom_range(0, 63) == 0) no_idle = ~no_idle;
				// back the block up with the sender still offering
				if ((p == 2 || p == 8) && n == 50) hold_req = 1'b1;
				b = rand_offer(board.min_votes);
				send_offer(b);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.expected_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
